// ===== hdl/bounded_ordered_list_engine_defines.svh =====
// ----------------------------------------------------------------------------
// Bounded ordered list engine: assertion macros
// Shared wrappers for the concurrent checks of the list engine.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_ORDERED_LIST_ENGINE_DEFINES_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_DEFINES_SVH

// Check on an explicit clock and active-low reset.
`define BOLE_ASSERT_AT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bounded ordered list engine check failed");

// Check on the block clock and reset.
`define BOLE_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("bounded ordered list engine check failed");

`endif

// ===== hdl/bole_pkg.sv =====
// ----------------------------------------------------------------------------
// Bounded ordered list engine: package
// Operation codes, status codes and the control word shared by the cells.
// ----------------------------------------------------------------------------
`default_nettype none

package bole_pkg;

    localparam int FUNC_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 5;

    localparam logic [FUNC_W-1:0] FN_APPEND = 3'd0;
    localparam logic [FUNC_W-1:0] FN_INSERT = 3'd1;
    localparam logic [FUNC_W-1:0] FN_SORTED = 3'd2;
    localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd3;
    localparam logic [FUNC_W-1:0] FN_SEARCH = 3'd4;

    localparam logic [STATUS_W-1:0] STS_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] STS_BADPOS = 2'd1;
    localparam logic [STATUS_W-1:0] STS_FULL   = 2'd2;

    typedef enum logic [1:0] {
        MD_NONE   = 2'd0,
        MD_INSERT = 2'd1,
        MD_REMOVE = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        SL_NONE  = 3'd0,
        SL_TAIL  = 3'd1,
        SL_INDEX = 3'd2,
        SL_GE    = 3'd3,
        SL_EQ    = 3'd4
    } t_sel;

    typedef struct packed {
        logic  cmp_en;
        logic  upd_en;
        t_mode mode;
        t_sel  sel;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_UPD  = 2'b10
    } t_state;

endpackage

`default_nettype wire

// ===== hdl/bole_if.sv =====
// ----------------------------------------------------------------------------
// Bounded ordered list engine: channel interfaces
// Valid/ready channels for operation requests and their results.
// ----------------------------------------------------------------------------
`default_nettype none

interface bole_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         func;
    logic signed [31:0] value;
    logic [4:0]         position;

    modport source (output valid, output func, output value, output position, input ready);
    modport sink   (input valid, input func, input value, input position, output ready);
endinterface

interface bole_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [4:0] found_position;
    logic [4:0] length;
    logic       is_empty;

    modport source (output valid, output status, output found_position, output length,
                    output is_empty, input ready);
    modport sink   (input valid, input status, input found_position, input length,
                    input is_empty, output ready);
endinterface

`default_nettype wire

// ===== hdl/bole_cell.sv =====
// ----------------------------------------------------------------------------
// Bounded ordered list engine: list cell
// Holds one entry, compares it with the request value and shifts with its
// neighbours on insert and remove.
// ----------------------------------------------------------------------------
`default_nettype none

module bole_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire bole_pkg::t_cell_ctl   i_ctl,
    input  wire logic [DATA_WIDTH-1:0] i_cmp_value,
    input  wire logic [DATA_WIDTH-1:0] i_value,
    input  wire logic                  i_valid,
    input  wire logic                  i_idx_hit,
    input  wire logic [DATA_WIDTH-1:0] i_left,
    input  wire logic [DATA_WIDTH-1:0] i_right,
    input  wire logic                  i_passed,
    output logic                       o_passed,
    output logic                       o_first,
    output logic [DATA_WIDTH-1:0]      o_data
);
    import bole_pkg::*;

    logic [DATA_WIDTH-1:0] r_data;
    logic                  r_eq;
    logic                  r_ge;
    logic                  w_here;

    always_comb begin
        case (i_ctl.sel)
            SL_TAIL:  w_here = !i_valid;
            SL_INDEX: w_here = i_idx_hit;
            SL_GE:    w_here = !i_valid || r_ge;
            SL_EQ:    w_here = i_valid && r_eq;
            default:  w_here = 1'b0;
        endcase
    end

    assign o_passed = i_passed || w_here;
    assign o_first  = w_here && !i_passed;
    assign o_data   = r_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp_en) begin
            r_eq <= (r_data == i_cmp_value);
            r_ge <= ($signed(r_data) >= $signed(i_cmp_value));
        end
        if (i_ctl.upd_en) begin
            case (i_ctl.mode)
                MD_INSERT: begin
                    if (i_passed) begin
                        r_data <= i_left;
                    end else if (w_here) begin
                        r_data <= i_value;
                    end
                end
                MD_REMOVE: begin
                    if (i_passed || w_here) begin
                        r_data <= i_right;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/bounded_ordered_list_engine.sv =====
// ----------------------------------------------------------------------------
// Bounded ordered list engine: top level
// Requests are taken one at a time; the next waits for the last one's result.
// The cells compare in the accept cycle and shift once the result slot is free.
// Reset clears the length and both channels; entries hold no reset value.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_ordered_list_engine #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bole_req_if.sink   i_req,
    bole_rsp_if.source o_rsp
);
    import bole_pkg::*;

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int IW   = $clog2(CAPACITY);
    localparam int EW   = ((CW > POS_W) ? CW : POS_W) + 1;
    localparam int MAXW = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_old_count;
    t_mode                 r_mode;
    t_sel                  r_sel;
    logic [IW-1:0]         r_idx;
    logic [DATA_WIDTH-1:0] r_value;
    logic [STATUS_W-1:0]   r_status;

    logic                  r_out_valid;
    logic [STATUS_W-1:0]   r_out_status;
    logic [LEN_W-1:0]      r_out_found;
    logic [LEN_W-1:0]      r_out_len;
    logic                  r_out_empty;

    logic                  w_accept;
    logic                  w_upd;
    logic                  w_full;
    logic signed [MAXW-1:0] w_wide;
    logic [DATA_WIDTH-1:0] w_value;
    logic [EW-1:0]         w_cnt_ext;
    logic [EW-1:0]         w_pos_ext;
    logic [EW-1:0]         w_pos_m1;
    t_mode                 d_mode;
    t_sel                  d_sel;
    logic [STATUS_W-1:0]   d_status;
    logic [CW-1:0]         d_count;
    t_cell_ctl             w_ctl;
    logic [CW-1:0]         w_found;

    logic [DATA_WIDTH-1:0] w_ext [0:CAPACITY+1];
    logic                  w_passed [0:CAPACITY];
    logic [CAPACITY-1:0]   w_first;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_upd       = (r_state == S_UPD) && (!r_out_valid || o_rsp.ready);

    assign w_wide    = MAXW'(i_req.value);
    assign w_value   = w_wide[DATA_WIDTH-1:0];
    assign w_full    = (r_count == CW'(CAPACITY));
    assign w_cnt_ext = EW'(r_count);
    assign w_pos_ext = EW'(i_req.position);
    assign w_pos_m1  = w_pos_ext - EW'(1);

    always_comb begin
        d_mode   = MD_NONE;
        d_sel    = SL_NONE;
        d_status = STS_DONE;
        d_count  = r_count;
        case (i_req.func)
            FN_APPEND: begin
                if (w_full) begin
                    d_status = STS_FULL;
                end else begin
                    d_mode  = MD_INSERT;
                    d_sel   = SL_TAIL;
                    d_count = r_count + CW'(1);
                end
            end
            FN_INSERT: begin
                if ((w_pos_ext == '0) || (w_pos_ext > w_cnt_ext + EW'(1))) begin
                    d_status = STS_BADPOS;
                end else if (w_full) begin
                    d_status = STS_FULL;
                end else begin
                    d_mode  = MD_INSERT;
                    d_sel   = SL_INDEX;
                    d_count = r_count + CW'(1);
                end
            end
            FN_SORTED: begin
                if (w_full) begin
                    d_status = STS_FULL;
                end else begin
                    d_mode  = MD_INSERT;
                    d_sel   = SL_GE;
                    d_count = r_count + CW'(1);
                end
            end
            FN_REMOVE: begin
                if ((w_pos_ext == '0) || (w_pos_ext > w_cnt_ext)) begin
                    d_status = STS_BADPOS;
                end else begin
                    d_mode  = MD_REMOVE;
                    d_sel   = SL_INDEX;
                    d_count = r_count - CW'(1);
                end
            end
            FN_SEARCH: begin
                d_sel = SL_EQ;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_accept) n_state = S_UPD;
            S_UPD:   if (w_upd) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_count <= d_count;
            end
            if (w_upd) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_old_count <= r_count;
            r_mode      <= d_mode;
            r_sel       <= d_sel;
            r_idx       <= w_pos_m1[IW-1:0];
            r_value     <= w_value;
            r_status    <= d_status;
        end
        if (w_upd) begin
            r_out_status <= r_status;
            r_out_found  <= (r_sel == SL_EQ) ? LEN_W'(w_found) : '0;
            r_out_len    <= LEN_W'(r_count);
            r_out_empty  <= (r_count == '0);
        end
    end

    assign w_ctl.cmp_en = w_accept;
    assign w_ctl.upd_en = w_upd;
    assign w_ctl.mode   = r_mode;
    assign w_ctl.sel    = r_sel;

    assign w_ext[0]            = r_value;
    assign w_ext[CAPACITY + 1] = w_ext[CAPACITY];
    assign w_passed[0]         = 1'b0;

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        bole_cell #(
            .DATA_WIDTH(DATA_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_cmp_value (w_value),
            .i_value     (r_value),
            .i_valid     (CW'(gi) < r_old_count),
            .i_idx_hit   (r_idx == IW'(gi)),
            .i_left      (w_ext[gi]),
            .i_right     (w_ext[gi + 2]),
            .i_passed    (w_passed[gi]),
            .o_passed    (w_passed[gi + 1]),
            .o_first     (w_first[gi]),
            .o_data      (w_ext[gi + 1])
        );
    end

    always_comb begin
        w_found = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_first[i]) begin
                w_found = w_found | CW'(i + 1);
            end
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_out_status;
    assign o_rsp.found_position = r_out_found;
    assign o_rsp.length         = r_out_len;
    assign o_rsp.is_empty       = r_out_empty;

endmodule

`default_nettype wire

// ===== hdl/bole_checker.sv =====
// ----------------------------------------------------------------------------
// Bounded ordered list engine: port checker
// Watches the request and result channels of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_ordered_list_engine_defines.svh"

module bole_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_req_valid,
    input wire logic       i_req_ready,
    input wire logic       i_rsp_valid,
    input wire logic       i_rsp_ready,
    input wire logic [1:0] i_rsp_status,
    input wire logic [4:0] i_rsp_found,
    input wire logic [4:0] i_rsp_length,
    input wire logic       i_rsp_empty
);
    import bole_pkg::*;

    `BOLE_ASSERT(a_rsp_hold, (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable({i_rsp_status, i_rsp_found, i_rsp_length, i_rsp_empty})))
    `BOLE_ASSERT(a_one_in_flight, (i_req_valid && i_req_ready) |=> !i_req_ready)
    `BOLE_ASSERT(a_empty_flag, i_rsp_valid |-> (i_rsp_empty == (i_rsp_length == '0)))
    `BOLE_ASSERT(a_status_code, i_rsp_valid |-> (i_rsp_status == STS_DONE || i_rsp_status == STS_BADPOS || i_rsp_status == STS_FULL))
    `BOLE_ASSERT_AT(a_found_in_list, i_clk, i_rst_n, i_rsp_valid |-> (i_rsp_found <= i_rsp_length))

endmodule

bind bounded_ordered_list_engine bole_checker u_bole_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_status (o_rsp.status),
    .i_rsp_found  (o_rsp.found_position),
    .i_rsp_length (o_rsp.length),
    .i_rsp_empty  (o_rsp.is_empty)
);

`default_nettype wire

// ===== tb/bounded_ordered_list_engine_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded ordered list engine: testbench
// Sends list operations over the request channel and checks each result against a
// behavioural model of the list kept by the bench, or against the expected result
// of a directed row that gives one. A short directed table covers the empty and
// full list, bad positions and the value extremes. Random phases follow, alternately
// growing and shrinking the list, under changing idle and stall patterns.
// ----------------------------------------------------------------------------

module bounded_ordered_list_engine_tb;

    import bole_pkg::*;

    localparam int CAPACITY    = 16;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 180;

    localparam logic [FUNC_W-1:0] FN_SPARE_5 = 3'd5;
    localparam logic [FUNC_W-1:0] FN_SPARE_7 = 3'd7;

    localparam logic signed [VALUE_W-1:0] VAL_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] VAL_MIN  = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_ZERO = 32'sh0000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_NEG1 = 32'shFFFF_FFFF;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    found;
        logic [LEN_W-1:0]    length;
        logic                is_empty;
    } t_list_result;

    typedef struct packed {
        logic [FUNC_W-1:0]         op;
        logic signed [VALUE_W-1:0] val;
        logic [POS_W-1:0]          pos;
        logic [4:0]                reps;
        logic                      has_want;
        t_list_result              want;
    } t_dir_row;

    logic clk;
    logic rst_n;

    bole_req_if req_ch ();
    bole_rsp_if rsp_ch ();

    bounded_ordered_list_engine #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (VALUE_W)
    ) u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    logic signed [VALUE_W-1:0] list_entries[$];
    t_list_result              list_results_due[$];
    t_dir_row                  dir_rows[$];

    int err_count     = 0;
    int result_idx    = 0;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_requested = 0;
    int hold_served    = 0;
    int hold_left      = 0;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] transaction %0d: %s", $realtime, result_idx, msg);
        err_count++;
    endtask

    function automatic t_list_result apply_list_op(input logic [FUNC_W-1:0] op,
                                                   input logic signed [VALUE_W-1:0] val,
                                                   input logic [POS_W-1:0] pos);
        t_list_result res;
        int count;
        int slot;
        res = '0;
        res.status = STS_DONE;
        count = list_entries.size();
        case (op)
            FN_APPEND: begin
                if (count >= CAPACITY) res.status = STS_FULL;
                else list_entries.push_back(val);
            end
            FN_INSERT: begin
                if (pos == 0 || int'(pos) > count + 1) res.status = STS_BADPOS;
                else if (count >= CAPACITY) res.status = STS_FULL;
                else list_entries.insert(int'(pos) - 1, val);
            end
            FN_SORTED: begin
                if (count >= CAPACITY) begin
                    res.status = STS_FULL;
                end else begin
                    slot = 0;
                    while (slot < count && list_entries[slot] < val) slot++;
                    list_entries.insert(slot, val);
                end
            end
            FN_REMOVE: begin
                if (pos == 0 || int'(pos) > count) res.status = STS_BADPOS;
                else list_entries.delete(int'(pos) - 1);
            end
            FN_SEARCH: begin
                slot = 0;
                while (slot < count && list_entries[slot] != val) slot++;
                if (slot < count) res.found = POS_W'(slot + 1);
            end
            default: begin
            end
        endcase
        res.length   = LEN_W'(list_entries.size());
        res.is_empty = (list_entries.size() == 0);
        return res;
    endfunction

    task automatic add_row(input logic [FUNC_W-1:0] op, input logic signed [VALUE_W-1:0] val,
                           input logic [POS_W-1:0] pos, input int reps, input logic has_want,
                           input logic [STATUS_W-1:0] sts, input int len, input logic empty);
        t_dir_row row;
        row.op            = op;
        row.val           = val;
        row.pos           = pos;
        row.reps          = 5'(reps);
        row.has_want      = has_want;
        row.want.status   = sts;
        row.want.found    = '0;
        row.want.length   = LEN_W'(len);
        row.want.is_empty = empty;
        dir_rows.push_back(row);
    endtask

    task automatic send_op(input logic [FUNC_W-1:0] op, input logic signed [VALUE_W-1:0] val,
                           input logic [POS_W-1:0] pos, input logic has_want,
                           input t_list_result want);
        t_list_result modelled;
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.func     <= op;
        req_ch.value    <= val;
        req_ch.position <= pos;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        modelled = apply_list_op(op, val, pos);
        list_results_due.push_back(has_want ? want : modelled);
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (list_results_due.size() != 0) @(posedge clk);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(99);
        if (roll < 35) return $urandom_range(8) - 4;
        if (roll < 39) return VAL_MAX;
        if (roll < 42) return VAL_MIN;
        if (roll < 45) return VAL_NEG1;
        if (roll < 65 && list_entries.size() > 0)
            return list_entries[$urandom_range(list_entries.size() - 1)];
        return $urandom;
    endfunction

    task automatic run_random(input int n);
        logic [FUNC_W-1:0] op;
        logic [POS_W-1:0]  pos;
        int                roll;
        int                count;
        logic              grow;
        grow = 1'b1;
        for (int k = 0; k < n; k++) begin
            if (k % 48 == 47) grow = !grow;
            count = list_entries.size();
            roll  = $urandom_range(99);
            if (roll < 4)
                op = FUNC_W'($urandom_range(FN_SPARE_7, FN_SPARE_5));
            else if (grow)
                op = roll < 29 ? FN_APPEND : roll < 54 ? FN_INSERT : roll < 74 ? FN_SORTED :
                     roll < 84 ? FN_REMOVE : FN_SEARCH;
            else
                op = roll < 12 ? FN_APPEND : roll < 20 ? FN_INSERT : roll < 28 ? FN_SORTED :
                     roll < 78 ? FN_REMOVE : FN_SEARCH;
            pos = POS_W'($urandom_range(31));
            if ($urandom_range(9) < 8) begin
                if (op == FN_INSERT) pos = POS_W'($urandom_range(count + 1, 1));
                else if (op == FN_REMOVE && count > 0) pos = POS_W'($urandom_range(count, 1));
            end
            send_op(op, pick_value(), pos, 1'b0, '0);
        end
    endtask

    // Result side: ready follows the stall rate, except during a requested hold-off.
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_served != hold_requested) begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge clk) begin
        t_list_result due;
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (list_results_due.size() == 0) begin
                report_mismatch("result with no transaction outstanding");
            end else begin
                due = list_results_due.pop_front();
                if (rsp_ch.status !== due.status)
                    report_mismatch($sformatf("status got %0d, expected %0d",
                                              rsp_ch.status, due.status));
                if (rsp_ch.found_position !== due.found)
                    report_mismatch($sformatf("found_position got %0d, expected %0d",
                                              rsp_ch.found_position, due.found));
                if (rsp_ch.length !== due.length)
                    report_mismatch($sformatf("length got %0d, expected %0d",
                                              rsp_ch.length, due.length));
                if (rsp_ch.is_empty !== due.is_empty)
                    report_mismatch($sformatf("is_empty got %0d, expected %0d",
                                              rsp_ch.is_empty, due.is_empty));
            end
            result_idx++;
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.func     = FN_APPEND;
        req_ch.value    = '0;
        req_ch.position = '0;

        //       op          value         pos rep chk  status      len empty
        add_row(FN_REMOVE,  VAL_ZERO,      1,  1, 1'b1, STS_BADPOS, 0, 1'b1);
        add_row(FN_SEARCH,  VAL_ZERO,      0,  1, 1'b1, STS_DONE,   0, 1'b1);
        add_row(FN_INSERT,  32'sd5,        0,  1, 1'b1, STS_BADPOS, 0, 1'b1);
        add_row(FN_INSERT,  32'sd5,        2,  1, 1'b1, STS_BADPOS, 0, 1'b1);
        add_row(FN_APPEND,  VAL_MAX,       0,  1, 1'b1, STS_DONE,   1, 1'b0);
        add_row(FN_APPEND,  VAL_MIN,       31, 1, 1'b1, STS_DONE,   2, 1'b0);
        add_row(FN_INSERT,  VAL_ZERO,      1,  1, 1'b0, STS_DONE,   0, 1'b0);
        add_row(FN_INSERT,  VAL_NEG1,      4,  1, 1'b0, STS_DONE,   0, 1'b0);
        add_row(FN_INSERT,  32'sd3,        6,  1, 1'b1, STS_BADPOS, 4, 1'b0);
        add_row(FN_SORTED,  -32'sd5,       0,  1, 1'b0, STS_DONE,   0, 1'b0);
        add_row(FN_SORTED,  VAL_MIN,       0,  1, 1'b0, STS_DONE,   0, 1'b0);
        add_row(FN_SORTED,  VAL_MAX,       0,  1, 1'b0, STS_DONE,   0, 1'b0);
        add_row(FN_SEARCH,  VAL_MIN,       0,  1, 1'b0, STS_DONE,   0, 1'b0);
        add_row(FN_SEARCH,  32'sd12345,    0,  1, 1'b0, STS_DONE,   0, 1'b0);
        add_row(FN_REMOVE,  VAL_ZERO,      0,  1, 1'b1, STS_BADPOS, 7, 1'b0);
        add_row(FN_REMOVE,  VAL_ZERO,      8,  1, 1'b1, STS_BADPOS, 7, 1'b0);
        add_row(FN_REMOVE,  VAL_ZERO,      7,  1, 1'b0, STS_DONE,   0, 1'b0);
        add_row(FN_SPARE_5, VAL_NEG1,      31, 1, 1'b1, STS_DONE,   6, 1'b0);
        add_row(FN_SPARE_7, VAL_MAX,       1,  1, 1'b1, STS_DONE,   6, 1'b0);
        add_row(FN_APPEND,  32'sh5555_5555, 0, 10, 1'b0, STS_DONE,  0, 1'b0);
        add_row(FN_APPEND,  32'sh2AAA_AAAA, 0, 1, 1'b1, STS_FULL,  16, 1'b0);
        add_row(FN_INSERT,  VAL_ZERO,      1,  1, 1'b1, STS_FULL,  16, 1'b0);
        add_row(FN_INSERT,  VAL_ZERO,      18, 1, 1'b1, STS_BADPOS, 16, 1'b0);
        add_row(FN_SORTED,  VAL_MIN,       0,  1, 1'b1, STS_FULL,  16, 1'b0);
        add_row(FN_REMOVE,  VAL_ZERO,      16, 1, 1'b0, STS_DONE,   0, 1'b0);
        add_row(FN_SEARCH,  32'sh5555_5555, 0, 1, 1'b0, STS_DONE,   0, 1'b0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[r])
            repeat (dir_rows[r].reps)
                send_op(dir_rows[r].op, dir_rows[r].val, dir_rows[r].pos,
                        dir_rows[r].has_want, dir_rows[r].want);

        // The result side holds off for a long stretch while requests keep coming.
        hold_requested++;
        run_random(PHASE_ITEMS);

        send_idle_pct = 58;
        run_random(PHASE_ITEMS);

        drain_results();
        send_idle_pct = 0;
        stall_pct     = 58;
        run_random(PHASE_ITEMS);

        send_idle_pct = 19;
        stall_pct     = 19;
        run_random(PHASE_ITEMS);

        drain_results();
        repeat (10) @(posedge clk);
        if (list_results_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", list_results_due.size()));

        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
